// ----- hw/rtl/dlq_pkg.sv -----
// package for the dual linked queue block: widths, payload types, state codes
// no dependencies

package dlq_pkg;

    localparam int NODE_COUNT = 64;
    localparam int PTR_W      = $clog2(NODE_COUNT) + 1;
    localparam int IDX_W      = $clog2(NODE_COUNT);
    localparam int CNT_W      = $clog2(NODE_COUNT + 1);
    localparam int ID_W       = 24;
    localparam int GRADE_W    = 10;

    localparam logic [PTR_W-1:0] NIL = PTR_W'(NODE_COUNT);

    typedef enum logic [1:0] {
        K_INSERT = 2'd0,
        K_REMOVE = 2'd1,
        K_PEEK   = 2'd2,
        K_SPLIT  = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0]         kind;
        logic               queue_sel;
        logic [ID_W-1:0]    student_id;
        logic [GRADE_W-1:0] grade_one;
        logic [GRADE_W-1:0] grade_two;
        logic [GRADE_W-1:0] grade_three;
    } t_in;

    typedef struct packed {
        logic               ok;
        logic               head_valid;
        logic [ID_W-1:0]    head_id;
        logic [GRADE_W-1:0] head_grade_one;
        logic [GRADE_W-1:0] head_grade_two;
        logic [GRADE_W-1:0] head_grade_three;
        logic [6:0]         count_zero;
        logic [6:0]         count_one;
    } t_out;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_REM_RD,
        S_REM_WAIT,
        S_SPL_RD,
        S_SPL_WAIT,
        S_SPL_FREE,
        S_HEAD_RD,
        S_HEAD_WAIT,
        S_OUT
    } t_state;

endpackage

// ----- hw/rtl/dlq_if.sv -----
// valid/ready channel interface carrying one packed payload
// depends on nothing; payload type given by the user

interface dlq_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/dual_linked_queue_with_split_core.sv -----
// top level: two linked fifo queues sharing a node store, with split
// depends on dlq_pkg and dlq_if

// One item at a time. After reset a link init pass over all NODE_COUNT (64) nodes
// chains them as free; no item is accepted meanwhile. Insert and remove read
// the node at the head of the free list or queue, write its link, chain it onto
// a tail and then read the queue head for the result; peek and a failed insert
// or remove go straight to the head read. Split reads one node at a time through
// the single node-memory read port until the end of the queue or until the
// record at position pos matches. The result stays in an output register until
// taken; a stalled result holds the next item in its last cycle.
module dual_linked_queue_with_split_core
    import dlq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    dlq_if.sink   s_in,
    dlq_if.source m_out
);

    // node memories, one read port with registered data
    logic [ID_W-1:0]      mem_id   [NODE_COUNT];
    logic [3*GRADE_W-1:0] mem_gr   [NODE_COUNT];
    logic [PTR_W-1:0]     mem_link [NODE_COUNT];

    logic [IDX_W-1:0]     rd_addr;
    logic                 rd_en;
    logic [ID_W-1:0]      rd_id;
    logic [3*GRADE_W-1:0] rd_gr;
    logic [PTR_W-1:0]     rd_link;

    logic                 wl_en, wd_en;
    logic [IDX_W-1:0]     wl_addr, wd_addr;
    logic [PTR_W-1:0]     wl_data;

    t_state r_state, n_state;
    t_in    r_item;
    t_out   r_res;
    logic   r_res_v;

    logic [PTR_W-1:0] r_qh [2];
    logic [PTR_W-1:0] r_qt [2];
    logic [CNT_W-1:0] r_qc [2];
    logic [PTR_W-1:0] r_fh, r_ft;
    logic [PTR_W-1:0] r_p;
    logic [CNT_W-1:0] r_pos;
    logic [IDX_W-1:0] r_init;
    logic             r_ok;
    logic [PTR_W-1:0] r_oh, r_ot;

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            rd_id   <= mem_id[rd_addr];
            rd_gr   <= mem_gr[rd_addr];
            rd_link <= mem_link[rd_addr];
        end
        if (wl_en) mem_link[wl_addr] <= wl_data;
        if (wd_en) begin
            mem_id[wd_addr] <= r_item.student_id;
            mem_gr[wd_addr] <= {r_item.grade_one, r_item.grade_two, r_item.grade_three};
        end
    end

    logic q, d;
    assign q = r_item.queue_sel;
    assign d = ~q;

    assign s_in.ready = (r_state == S_IDLE);
    assign m_out.valid = r_res_v;
    assign m_out.data  = r_res;

    // next state and memory control
    always_comb begin
        n_state = r_state;
        rd_en   = 1'b0;
        rd_addr = '0;
        wl_en   = 1'b0;
        wl_addr = '0;
        wl_data = NIL;
        wd_en   = 1'b0;
        wd_addr = r_fh[IDX_W-1:0];
        unique case (r_state)
            S_INIT: begin
                wl_en   = 1'b1;
                wl_addr = r_init;
                wl_data = PTR_W'(r_init) + PTR_W'(1);
                if (r_init == IDX_W'(NODE_COUNT - 1)) n_state = S_IDLE;
            end
            S_IDLE: if (s_in.valid) n_state = S_DISPATCH;
            S_DISPATCH: begin
                case (r_item.kind)
                    K_INSERT: begin
                        if (r_fh != NIL) begin
                            rd_en   = 1'b1;
                            rd_addr = r_fh[IDX_W-1:0];
                            n_state = S_REM_WAIT;
                        end else n_state = S_HEAD_RD;
                    end
                    K_REMOVE: begin
                        if (r_qh[q] != NIL) begin
                            rd_en   = 1'b1;
                            rd_addr = r_qh[q][IDX_W-1:0];
                            n_state = S_REM_WAIT;
                        end else n_state = S_HEAD_RD;
                    end
                    K_PEEK: n_state = S_HEAD_RD;
                    default: n_state = S_SPL_RD;
                endcase
            end
            S_REM_WAIT: n_state = S_REM_RD;
            S_REM_RD: begin
                if (r_item.kind == K_INSERT) begin
                    wd_en   = 1'b1;
                    wl_en   = 1'b1;
                    wl_addr = r_fh[IDX_W-1:0];
                    wl_data = NIL;
                end else begin
                    wl_en   = 1'b1;
                    wl_addr = r_qh[q][IDX_W-1:0];
                    wl_data = NIL;
                end
                n_state = S_SPL_FREE;
            end
            S_SPL_RD: begin
                if (r_p != NIL && r_pos < r_qc[q]) begin
                    rd_en   = 1'b1;
                    rd_addr = r_p[IDX_W-1:0];
                    n_state = S_SPL_WAIT;
                end else n_state = S_HEAD_RD;
            end
            S_SPL_WAIT: begin
                if (rd_id == r_item.student_id && rd_link != NIL) begin
                    wl_en   = 1'b1;
                    wl_addr = r_p[IDX_W-1:0];
                    wl_data = NIL;
                    n_state = S_SPL_FREE;
                end else n_state = S_SPL_RD;
            end
            S_SPL_FREE: begin
                // second link write: chain onto a tail
                n_state = S_HEAD_RD;
                if (r_item.kind == K_INSERT) begin
                    if (r_qh[q] != NIL) begin
                        wl_en = 1'b1;
                        wl_addr = r_qt[q][IDX_W-1:0];
                        wl_data = r_p;
                    end
                end else if (r_item.kind == K_REMOVE) begin
                    if (r_fh != NIL) begin
                        wl_en = 1'b1;
                        wl_addr = r_ft[IDX_W-1:0];
                        wl_data = r_p;
                    end
                end else if (r_oh != NIL && r_fh != NIL) begin
                    wl_en = 1'b1;
                    wl_addr = r_ft[IDX_W-1:0];
                    wl_data = r_oh;
                end
            end
            S_HEAD_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_qh[q][IDX_W-1:0];
                n_state = S_HEAD_WAIT;
            end
            S_HEAD_WAIT: n_state = S_OUT;
            S_OUT: if (!r_res_v || m_out.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state, queue registers and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_init  <= '0;
            r_res_v <= 1'b0;
            for (int i = 0; i < 2; i++) begin
                r_qh[i] <= NIL;
                r_qt[i] <= NIL;
                r_qc[i] <= '0;
            end
            r_fh <= '0;
            r_ft <= PTR_W'(NODE_COUNT - 1);
        end else begin
            r_state <= n_state;
            if (r_res_v && m_out.ready && r_state != S_OUT) r_res_v <= 1'b0;
            unique case (r_state)
                S_INIT: r_init <= r_init + IDX_W'(1);
                S_IDLE: if (s_in.valid) r_item <= s_in.data;
                S_DISPATCH: begin
                    r_ok  <= (r_item.kind == K_PEEK) && (r_qh[q] != NIL);
                    r_p   <= r_qh[q];
                    r_pos <= '0;
                end
                S_REM_RD: begin
                    r_ok <= 1'b1;
                    if (r_item.kind == K_INSERT) begin
                        r_p  <= r_fh;
                        r_fh <= rd_link;
                        if (rd_link == NIL) r_ft <= NIL;
                    end else begin
                        r_p     <= r_qh[q];
                        r_qh[q] <= rd_link;
                        if (rd_link == NIL) r_qt[q] <= NIL;
                        if (r_qc[q] != '0) r_qc[q] <= r_qc[q] - CNT_W'(1);
                    end
                end
                S_SPL_WAIT: begin
                    if (rd_id == r_item.student_id && rd_link != NIL) begin
                        r_ok    <= 1'b1;
                        r_qh[d] <= rd_link;
                        r_qt[d] <= r_qt[q];
                        r_qc[d] <= r_qc[q] - (r_pos + CNT_W'(1));
                        r_qt[q] <= r_p;
                        r_qc[q] <= r_pos + CNT_W'(1);
                    end else begin
                        r_p   <= rd_link;
                        r_pos <= r_pos + CNT_W'(1);
                    end
                end
                S_SPL_FREE: begin
                    if (r_item.kind == K_INSERT) begin
                        if (r_qh[q] == NIL) r_qh[q] <= r_p;
                        r_qt[q] <= r_p;
                        r_qc[q] <= r_qc[q] + CNT_W'(1);
                    end else if (r_item.kind == K_REMOVE) begin
                        if (r_fh == NIL) r_fh <= r_p;
                        r_ft <= r_p;
                    end else if (r_qh[d] != NIL) begin
                        // old chain of the receiving queue, captured before update
                    end
                end
                S_OUT: begin
                    if (!r_res_v || m_out.ready) begin
                        r_res_v <= 1'b1;
                        r_res.ok <= r_ok;
                        r_res.head_valid <= (r_qh[q] != NIL);
                        r_res.head_id <= (r_qh[q] != NIL) ? rd_id : '0;
                        r_res.head_grade_one <= (r_qh[q] != NIL) ?
                            rd_gr[3*GRADE_W-1:2*GRADE_W] : '0;
                        r_res.head_grade_two <= (r_qh[q] != NIL) ?
                            rd_gr[2*GRADE_W-1:GRADE_W] : '0;
                        r_res.head_grade_three <= (r_qh[q] != NIL) ?
                            rd_gr[GRADE_W-1:0] : '0;
                        r_res.count_zero <= 7'(r_qc[0]);
                        r_res.count_one  <= 7'(r_qc[1]);
                    end
                end
                default: ;
            endcase
            // split: capture the receiving queue's old chain at match time, free it in S_SPL_FREE
            if (r_state == S_SPL_WAIT && rd_id == r_item.student_id
                    && rd_link != NIL) begin
                r_oh <= r_qh[d];
                r_ot <= r_qt[d];
            end
            if (r_state == S_SPL_FREE && r_item.kind == K_SPLIT && r_oh != NIL) begin
                if (r_fh == NIL) r_fh <= r_oh;
                r_ft <= r_ot;
            end
        end
    end

endmodule

// ----- hw/rtl/dlq_checker.sv -----
// port-level checks for the dual linked queue block
// depends on dlq_pkg and dlq_if; bound to the top level

module dlq_checker
    import dlq_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input t_out out_data
);

    // output held while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // counts never exceed store size
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> (out_data.count_zero + out_data.count_one) <= 8'(NODE_COUNT))
        else $error("counts exceed store");

    // empty head id reads as zero
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_data.head_valid |-> out_data.head_id == '0)
        else $error("empty head not zero");

    // no transfer accepted in the cycle after an accept
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("back to back accept");

endmodule

bind dual_linked_queue_with_split_core dlq_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(s_in.valid), .in_ready(s_in.ready),
    .out_valid(m_out.valid), .out_ready(m_out.ready), .out_data(m_out.data)
);
